// ===== src/prqs_pkg.sv =====
package prqs_pkg;

	localparam int SLOTS         = 32;
	localparam int PID_BITS      = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int CMP_W  = (PID_BITS > 16) ? PID_BITS : 16;

	// link value that ends a list
	localparam logic [LINK_W-1:0] NIL_LINK     = LINK_W'(SLOTS);
	localparam logic [5:0]        MAX_PROC_RST = 6'd20;

	localparam logic [2:0] ACT_CREATE    = 3'd0;
	localparam logic [2:0] ACT_DISPATCH  = 3'd1;
	localparam logic [2:0] ACT_REQUEUE   = 3'd2;
	localparam logic [2:0] ACT_TERMINATE = 3'd3;
	localparam logic [2:0] ACT_SUSPEND   = 3'd4;
	localparam logic [2:0] ACT_RESUME    = 3'd5;
	localparam logic [2:0] ACT_CHANGE    = 3'd6;
	localparam logic [2:0] ACT_QUERY     = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_LIMIT     = 3'd1;
	localparam logic [2:0] ST_BAD_PRIO  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic [1:0] LOC_ABSENT    = 2'd0;
	localparam logic [1:0] LOC_RUNNING   = 2'd1;
	localparam logic [1:0] LOC_READY     = 2'd2;
	localparam logic [1:0] LOC_SUSPENDED = 2'd3;

	// one slot of the process store
	typedef struct packed {
		logic [LINK_W-1:0]        link;
		logic [PRIORITY_BITS-1:0] prio;
		logic [PID_BITS-1:0]      pid;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	// stored pid against the 17-bit signed target; -1 never matches
	function automatic logic pid_match(input logic [PID_BITS-1:0] sp, input logic [16:0] tp);
		logic hit;
		hit = !tp[16] && (CMP_W'(sp) == CMP_W'(tp[15:0]));
		return hit;
	endfunction

endpackage

// ===== src/prqs_ram.sv =====
module prqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/prqs_alloc.sv =====
module prqs_alloc
	import prqs_pkg::*;
(
	input  logic [SLOTS-1:0] used,
	output logic             free_ok,
	output logic [IDX_W-1:0] free_idx
);

	// lowest free slot
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_ok  = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

endmodule

// ===== src/priority_ready_queue_scheduler.sv =====
// Process scheduler: up to SLOTS processes, one running, a ready list sorted by
// priority (lower value first, FIFO among equals) and a FIFO suspend list. Each
// command transaction on s_* gives exactly one result transaction on m_*; one
// command is worked on at a time and the next is taken while the previous
// result still waits in the output register. Pid, priority and link of every
// slot live in one RAM with a registered read, and all list work is
// a walk over it at one slot per cycle, followed by one or two write-backs.
// max_processes (APB address 0) caps the live process count; the user must
// write it only while the block is idle, which the block itself does not enforce.
module priority_ready_queue_scheduler
	import prqs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command: [2:0] action, [19:3] pid, [28:20] priority_req, [31:29] zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// result: [2:0] status, [18:3] result_pid, [20:19] location,
	// [21] ready_empty, [23:22] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_WSTART, S_WALK, S_POST, S_UNLINK,
		S_INS_GO, S_INS_W1, S_INS_W2, S_INS_RET,
		S_APP_GO, S_APP_W1, S_APP_W2,
		S_DISP_RD, S_DISP_DATA, S_RES_RD, S_RES_DATA, S_CHG_W, S_DONE
	} state_t;

	// what a list walk stops on
	typedef enum logic [1:0] {
		WM_FIND, WM_INS, WM_TAIL
	} wmode_t;

	state_t state_q;
	wmode_t mode_q;

	logic [5:0]             max_q;
	logic [SLOTS-1:0]       used_q;
	logic [LINK_W-1:0]      ready_head_q, susp_head_q, running_q;
	logic [PID_BITS-1:0]    run_pid_q;
	logic [PRIORITY_BITS-1:0] run_prio_q;
	logic [LINK_W-1:0]      live_q;
	logic [PID_BITS-1:0]    next_pid_q;

	// command being worked
	logic [2:0]             act_q;
	logic [16:0]            pid_q;
	logic [8:0]             prio_q;

	// walk registers
	logic [LINK_W-1:0]      cur_q, prv_q, nx_q;
	ent_t                   cur_ent_q, prv_ent_q, s_ent_q;
	logic [IDX_W-1:0]       s_q;
	logic                   lst_q;     // 0 ready list, 1 suspend list
	logic                   ph_q;      // second search of change / query
	logic                   found_q;
	logic                   tail_nil_q;

	// result
	logic                   out_valid_q;
	logic [2:0]             st_q;
	logic [15:0]            rpid_q;
	logic [1:0]             loc_q;
	logic [2:0]             o_st_q;
	logic [15:0]            o_rpid_q;
	logic [1:0]             o_loc_q;
	logic                   o_empty_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr, ram_raddr;
	ent_t                   ram_wdata;
	logic [ENT_W-1:0]       ram_rdata;
	ent_t                   rd_ent;

	logic                   free_ok;
	logic [IDX_W-1:0]       free_idx;

	logic                   cfg_wr;
	logic                   pid_all, run_hit, prio_bad, at_limit;
	logic [8:0]             limit;
	logic [7:0]             prio_hi;

	prqs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	prqs_alloc u_alloc (
		.used     (used_q),
		.free_ok  (free_ok),
		.free_idx (free_idx)
	);

	assign rd_ent  = ent_t'(ram_rdata);
	assign pid_all = (pid_q == 17'h1FFFF);
	assign run_hit = (running_q != NIL_LINK) && pid_match(run_pid_q, pid_q);
	assign prio_hi = prio_q[7:0] >> PRIORITY_BITS;
	assign prio_bad = prio_q[8] || (prio_hi != 8'd0);
	assign limit   = (9'(max_q) < 9'(SLOTS)) ? 9'(max_q) : 9'(SLOTS);
	assign at_limit = (9'(live_q) >= limit);

	// APB: always ready, single register at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {26'd0, max_q} : 32'd0;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, o_empty_q, o_loc_q, o_rpid_q, o_st_q};

	// Walk reads follow the link just returned; everywhere else the RAM reads
	// cur_q. No state consumes read data right after a write, so no bypass.
	always_comb begin
		ram_raddr = (state_q == S_WALK) ? rd_ent.link[IDX_W-1:0] : cur_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = cur_q[IDX_W-1:0];
		ram_wdata = '0;
		case (state_q)
			S_INS_W1: begin
				ram_we    = 1'b1;
				ram_waddr = s_q;
				ram_wdata = '{link: cur_q, prio: s_ent_q.prio, pid: s_ent_q.pid};
			end
			S_INS_W2: begin
				ram_we    = 1'b1;
				ram_waddr = prv_q[IDX_W-1:0];
				ram_wdata = '{link: LINK_W'(s_q), prio: prv_ent_q.prio, pid: prv_ent_q.pid};
			end
			S_UNLINK: begin
				ram_we    = (prv_q != NIL_LINK);
				ram_waddr = prv_q[IDX_W-1:0];
				ram_wdata = '{link: cur_ent_q.link, prio: prv_ent_q.prio, pid: prv_ent_q.pid};
			end
			S_APP_W1: begin
				ram_we    = 1'b1;
				ram_waddr = s_q;
				ram_wdata = '{link: NIL_LINK, prio: s_ent_q.prio, pid: s_ent_q.pid};
			end
			S_APP_W2: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[IDX_W-1:0];
				ram_wdata = '{link: LINK_W'(s_q), prio: cur_ent_q.prio, pid: cur_ent_q.pid};
			end
			S_CHG_W: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[IDX_W-1:0];
				ram_wdata = '{link: cur_ent_q.link, prio: PRIORITY_BITS'(prio_q[7:0]),
					pid: cur_ent_q.pid};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= WM_FIND;
			max_q        <= MAX_PROC_RST;
			used_q       <= '0;
			ready_head_q <= NIL_LINK;
			susp_head_q  <= NIL_LINK;
			running_q    <= NIL_LINK;
			live_q       <= '0;
			next_pid_q   <= '0;
			out_valid_q  <= 1'b0;
			cur_q        <= NIL_LINK;
			prv_q        <= NIL_LINK;
			lst_q        <= 1'b0;
			ph_q         <= 1'b0;
			found_q      <= 1'b0;
			tail_nil_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				max_q <= pwdata[5:0];
			end
			// the closing step reloads the output register itself
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= s_tdata[2:0];
						pid_q   <= s_tdata[19:3];
						prio_q  <= s_tdata[28:20];
						rpid_q  <= s_tdata[18:3];
						st_q    <= ST_OK;
						loc_q   <= LOC_ABSENT;
						ph_q    <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						ACT_CREATE: begin
							if (at_limit || (!prio_bad && !free_ok)) begin
								st_q    <= ST_LIMIT;
								state_q <= S_DONE;
							end else if (prio_bad) begin
								st_q    <= ST_BAD_PRIO;
								state_q <= S_DONE;
							end else begin
								used_q[free_idx] <= 1'b1;
								s_q          <= free_idx;
								s_ent_q.pid  <= next_pid_q;
								s_ent_q.prio <= PRIORITY_BITS'(prio_q[7:0]);
								live_q       <= live_q + 1'b1;
								rpid_q       <= 16'(next_pid_q);
								next_pid_q   <= next_pid_q + 1'b1;
								state_q      <= S_INS_GO;
							end
						end
						ACT_DISPATCH: begin
							if (ready_head_q == NIL_LINK) begin
								st_q    <= ST_EMPTY;
								state_q <= S_DONE;
							end else if (running_q != NIL_LINK) begin
								s_q          <= running_q[IDX_W-1:0];
								s_ent_q.pid  <= run_pid_q;
								s_ent_q.prio <= run_prio_q;
								running_q    <= NIL_LINK;
								state_q      <= S_INS_GO;
							end else begin
								cur_q   <= ready_head_q;
								state_q <= S_DISP_RD;
							end
						end
						ACT_REQUEUE: begin
							if (running_q == NIL_LINK) begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								s_q          <= running_q[IDX_W-1:0];
								s_ent_q.pid  <= run_pid_q;
								s_ent_q.prio <= run_prio_q;
								running_q    <= NIL_LINK;
								state_q      <= S_INS_GO;
							end
						end
						ACT_TERMINATE: begin
							if (run_hit) begin
								used_q[running_q[IDX_W-1:0]] <= 1'b0;
								if (live_q != '0) begin
									live_q <= live_q - 1'b1;
								end
								running_q <= NIL_LINK;
								state_q   <= S_DONE;
							end else begin
								cur_q   <= ready_head_q;
								lst_q   <= 1'b0;
								mode_q  <= WM_FIND;
								state_q <= S_WSTART;
							end
						end
						ACT_SUSPEND: begin
							if ((running_q != NIL_LINK) && (pid_all || run_hit)) begin
								s_q          <= running_q[IDX_W-1:0];
								s_ent_q.pid  <= run_pid_q;
								s_ent_q.prio <= run_prio_q;
								running_q    <= NIL_LINK;
								state_q      <= S_APP_GO;
							end else if (pid_all) begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								cur_q   <= ready_head_q;
								lst_q   <= 1'b0;
								mode_q  <= WM_FIND;
								state_q <= S_WSTART;
							end
						end
						ACT_RESUME: begin
							if (pid_all) begin
								cur_q       <= susp_head_q;
								susp_head_q <= NIL_LINK;
								state_q     <= S_RES_RD;
							end else begin
								cur_q   <= susp_head_q;
								lst_q   <= 1'b1;
								mode_q  <= WM_FIND;
								state_q <= S_WSTART;
							end
						end
						ACT_CHANGE: begin
							if (prio_bad) begin
								st_q    <= ST_BAD_PRIO;
								state_q <= S_DONE;
							end else begin
								cur_q   <= ready_head_q;
								lst_q   <= 1'b0;
								mode_q  <= WM_FIND;
								state_q <= S_WSTART;
							end
						end
						default: begin
							if (run_hit) begin
								loc_q   <= LOC_RUNNING;
								state_q <= S_DONE;
							end else begin
								cur_q   <= ready_head_q;
								lst_q   <= 1'b0;
								mode_q  <= WM_FIND;
								state_q <= S_WSTART;
							end
						end
					endcase
				end
				S_WSTART: begin
					prv_q   <= NIL_LINK;
					state_q <= S_WALK;
				end
				S_WALK: begin
					case (mode_q)
						WM_FIND: begin
							if (cur_q == NIL_LINK) begin
								found_q <= 1'b0;
								state_q <= S_POST;
							end else if (pid_match(rd_ent.pid, pid_q)) begin
								found_q   <= 1'b1;
								cur_ent_q <= rd_ent;
								state_q   <= S_POST;
							end else begin
								prv_q     <= cur_q;
								prv_ent_q <= rd_ent;
								cur_q     <= rd_ent.link;
							end
						end
						WM_INS: begin
							if ((cur_q == NIL_LINK) || (rd_ent.prio > s_ent_q.prio)) begin
								state_q <= S_INS_W1;
							end else begin
								prv_q     <= cur_q;
								prv_ent_q <= rd_ent;
								cur_q     <= rd_ent.link;
							end
						end
						default: begin
							if (rd_ent.link == NIL_LINK) begin
								cur_ent_q <= rd_ent;
								state_q   <= S_APP_W1;
							end else begin
								cur_q <= rd_ent.link;
							end
						end
					endcase
				end
				S_POST: begin
					case (act_q)
						ACT_CHANGE, ACT_QUERY: begin
							if (found_q) begin
								if (act_q == ACT_QUERY) begin
									loc_q   <= ph_q ? LOC_SUSPENDED : LOC_READY;
									state_q <= S_DONE;
								end else begin
									state_q <= ph_q ? S_CHG_W : S_UNLINK;
								end
							end else if (!ph_q) begin
								ph_q    <= 1'b1;
								cur_q   <= susp_head_q;
								lst_q   <= 1'b1;
								state_q <= S_WSTART;
							end else begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end
						end
						default: begin
							if (found_q) begin
								state_q <= S_UNLINK;
							end else begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_UNLINK: begin
					if (prv_q == NIL_LINK) begin
						if (lst_q) begin
							susp_head_q <= cur_ent_q.link;
						end else begin
							ready_head_q <= cur_ent_q.link;
						end
					end
					s_q     <= cur_q[IDX_W-1:0];
					// a priority change carries the new value into the insert
					s_ent_q <= '{link: cur_ent_q.link,
						prio: (act_q == ACT_CHANGE) ? PRIORITY_BITS'(prio_q[7:0])
							: cur_ent_q.prio,
						pid: cur_ent_q.pid};
					case (act_q)
						ACT_TERMINATE: begin
							used_q[cur_q[IDX_W-1:0]] <= 1'b0;
							if (live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
							state_q <= S_DONE;
						end
						ACT_SUSPEND: begin
							state_q <= S_APP_GO;
						end
						default: begin
							state_q <= S_INS_GO;
						end
					endcase
				end
				S_INS_GO: begin
					cur_q   <= ready_head_q;
					mode_q  <= WM_INS;
					state_q <= S_WSTART;
				end
				S_INS_W1: begin
					if (prv_q == NIL_LINK) begin
						ready_head_q <= LINK_W'(s_q);
						state_q      <= S_INS_RET;
					end else begin
						state_q <= S_INS_W2;
					end
				end
				S_INS_W2: begin
					state_q <= S_INS_RET;
				end
				S_INS_RET: begin
					if (act_q == ACT_DISPATCH) begin
						cur_q   <= ready_head_q;
						state_q <= S_DISP_RD;
					end else if ((act_q == ACT_RESUME) && pid_all) begin
						cur_q   <= nx_q;
						state_q <= S_RES_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_APP_GO: begin
					if (susp_head_q == NIL_LINK) begin
						tail_nil_q <= 1'b1;
						state_q    <= S_APP_W1;
					end else begin
						tail_nil_q <= 1'b0;
						cur_q      <= susp_head_q;
						mode_q     <= WM_TAIL;
						state_q    <= S_WSTART;
					end
				end
				S_APP_W1: begin
					if (tail_nil_q) begin
						susp_head_q <= LINK_W'(s_q);
						state_q     <= S_DONE;
					end else begin
						state_q <= S_APP_W2;
					end
				end
				S_APP_W2: begin
					state_q <= S_DONE;
				end
				S_DISP_RD: begin
					state_q <= S_DISP_DATA;
				end
				S_DISP_DATA: begin
					ready_head_q <= rd_ent.link;
					running_q    <= cur_q;
					run_pid_q    <= rd_ent.pid;
					run_prio_q   <= rd_ent.prio;
					rpid_q       <= 16'(rd_ent.pid);
					state_q      <= S_DONE;
				end
				S_RES_RD: begin
					state_q <= (cur_q == NIL_LINK) ? S_DONE : S_RES_DATA;
				end
				S_RES_DATA: begin
					nx_q         <= rd_ent.link;
					s_q          <= cur_q[IDX_W-1:0];
					s_ent_q      <= rd_ent;
					state_q      <= S_INS_GO;
				end
				S_CHG_W: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						o_st_q      <= st_q;
						o_rpid_q    <= rpid_q;
						o_loc_q     <= loc_q;
						o_empty_q   <= (ready_head_q == NIL_LINK);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// one command in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in work");

	// a result is only raised from the closing step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside closing step");

	// the running process always owns a live slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(running_q != NIL_LINK) |-> used_q[running_q[IDX_W-1:0]])
		else $error("running process in a free slot");

	// live count tracks the used slots
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(used_q) == int'(live_q)))
		else $error("live count out of step with slot usage");

endmodule

// ===== test/tb_priority_ready_queue_scheduler.sv =====
module tb_priority_ready_queue_scheduler;
	import prqs_pkg::*;

	localparam int NIL      = SLOTS;
	localparam int WDOG_MAX = 40000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [2:0] action, [19:3] pid, [28:20] priority_req
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [2:0] status, [18:3] result_pid, [20:19] location, [21] ready_empty
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] rpid;
		logic [1:0]  loc;
		logic        empty;
	} sched_res_t;

	// Shadow scheduler plus the queue of answers it still owes.
	class sched_scoreboard;
		bit        used [SLOTS];
		bit [15:0] spid [SLOTS];
		bit [7:0]  sprio[SLOTS];
		int        link [SLOTS];
		int        rdy_head, sus_head, run_slot, live, cap;
		bit [15:0] pid_next;
		sched_res_t owed[$];
		int        errors, checked;

		function void clear();
			foreach (used[i]) begin
				used[i] = 0; link[i] = NIL;
			end
			rdy_head = NIL; sus_head = NIL; run_slot = NIL;
			live = 0; pid_next = 0; cap = 20;
			errors = 0; checked = 0;
		endfunction

		function automatic int find(int head, logic signed [16:0] pid, output int prev);
			int p, c, n;
			p = NIL; c = head; n = 0;
			while (c < NIL && n < NIL) begin
				if (pid >= 0 && spid[c] == pid[15:0]) begin
					prev = p;
					return c;
				end
				p = c; c = link[c]; n++;
			end
			prev = NIL;
			return NIL;
		endfunction

		function void unlink_rdy(int prev, int c);
			if (prev < NIL) link[prev] = link[c];
			else rdy_head = link[c];
		endfunction

		function void unlink_sus(int prev, int c);
			if (prev < NIL) link[prev] = link[c];
			else sus_head = link[c];
		endfunction

		function void rdy_insert(int s);
			int p, c, n;
			p = NIL; c = rdy_head; n = 0;
			while (c < NIL && n < NIL && sprio[c] <= sprio[s]) begin
				p = c; c = link[c]; n++;
			end
			link[s] = c;
			if (p < NIL) link[p] = s;
			else rdy_head = s;
		endfunction

		function void sus_append(int s);
			int c, n;
			link[s] = NIL;
			if (sus_head >= NIL) begin
				sus_head = s;
				return;
			end
			c = sus_head; n = 0;
			while (link[c] < NIL && n < NIL) begin
				c = link[c]; n++;
			end
			link[c] = s;
		endfunction

		function void drop(int s);
			used[s] = 0;
			if (live > 0) live--;
		endfunction

		// random pid of a live process, -1 when none
		function int pick_live();
			int idx[$];
			foreach (used[i]) if (used[i]) idx.push_back(i);
			if (idx.size() == 0) return -1;
			return spid[idx[$urandom_range(idx.size() - 1)]];
		endfunction

		function void note_command(logic [2:0] act, logic signed [16:0] pid,
				logic signed [8:0] prio);
			sched_res_t r;
			int s, prev, c, nx, n, lim;
			r.status = ST_OK; r.rpid = pid[15:0]; r.loc = LOC_ABSENT;
			case (act)
				ACT_CREATE: begin
					lim = (cap < NIL) ? cap : NIL;
					if (live >= lim) r.status = ST_LIMIT;
					else if (prio < 0) r.status = ST_BAD_PRIO;
					else begin
						for (s = 0; s < NIL && used[s]; s++) ;
						if (s >= NIL) r.status = ST_LIMIT;
						else begin
							used[s] = 1; spid[s] = pid_next; sprio[s] = prio[7:0];
							live++; r.rpid = pid_next; pid_next++;
							rdy_insert(s);
						end
					end
				end
				ACT_DISPATCH: begin
					if (rdy_head >= NIL) r.status = ST_EMPTY;
					else begin
						if (run_slot < NIL) rdy_insert(run_slot);
						s = rdy_head; rdy_head = link[s];
						run_slot = s; r.rpid = spid[s];
					end
				end
				ACT_REQUEUE: begin
					if (run_slot >= NIL) r.status = ST_NOT_FOUND;
					else begin
						rdy_insert(run_slot); run_slot = NIL;
					end
				end
				ACT_TERMINATE: begin
					if (run_slot < NIL && pid >= 0 && spid[run_slot] == pid[15:0]) begin
						drop(run_slot); run_slot = NIL;
					end else begin
						s = find(rdy_head, pid, prev);
						if (s >= NIL) r.status = ST_NOT_FOUND;
						else begin
							unlink_rdy(prev, s); drop(s);
						end
					end
				end
				ACT_SUSPEND: begin
					if (run_slot < NIL && (pid == -1 ||
							(pid >= 0 && spid[run_slot] == pid[15:0]))) begin
						sus_append(run_slot); run_slot = NIL;
					end else if (pid == -1) r.status = ST_NOT_FOUND;
					else begin
						s = find(rdy_head, pid, prev);
						if (s >= NIL) r.status = ST_NOT_FOUND;
						else begin
							unlink_rdy(prev, s); sus_append(s);
						end
					end
				end
				ACT_RESUME: begin
					if (pid == -1) begin
						c = sus_head; n = 0;
						while (c < NIL && n < NIL) begin
							nx = link[c]; rdy_insert(c); c = nx; n++;
						end
						sus_head = NIL;
					end else begin
						s = find(sus_head, pid, prev);
						if (s >= NIL) r.status = ST_NOT_FOUND;
						else begin
							unlink_sus(prev, s); rdy_insert(s);
						end
					end
				end
				ACT_CHANGE: begin
					if (prio < 0) r.status = ST_BAD_PRIO;
					else begin
						s = find(rdy_head, pid, prev);
						if (s < NIL) begin
							unlink_rdy(prev, s); sprio[s] = prio[7:0]; rdy_insert(s);
						end else begin
							s = find(sus_head, pid, prev);
							if (s >= NIL) r.status = ST_NOT_FOUND;
							else sprio[s] = prio[7:0];
						end
					end
				end
				default: begin
					if (run_slot < NIL && pid >= 0 && spid[run_slot] == pid[15:0])
						r.loc = LOC_RUNNING;
					else if (find(rdy_head, pid, prev) < NIL) r.loc = LOC_READY;
					else if (find(sus_head, pid, prev) < NIL) r.loc = LOC_SUSPENDED;
					else r.status = ST_NOT_FOUND;
				end
			endcase
			r.empty = (rdy_head >= NIL);
			owed.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch %0d: %s", errors, what);
			errors++;
		endtask

		task check_result(logic [23:0] d);
			sched_res_t w, g;
			g = {d[2:0], d[18:3], d[20:19], d[21]};
			checked++;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			w = owed.pop_front();
			if (g.status != w.status)
				report($sformatf("#%0d status %0d want %0d", checked, g.status, w.status));
			if (g.rpid != w.rpid)
				report($sformatf("#%0d result_pid %0d want %0d", checked, g.rpid, w.rpid));
			if (g.loc != w.loc)
				report($sformatf("#%0d location %0d want %0d", checked, g.loc, w.loc));
			if (g.empty != w.empty)
				report($sformatf("#%0d ready_empty %0d want %0d", checked, g.empty, w.empty));
		endtask
	endclass

	sched_scoreboard sb;
	bit quiet;          // no idling on either side
	int wdog;
	int act_seen[8];

	priority_ready_queue_scheduler dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall bursts unless quiet
	int stall_left;
	always @(posedge clk) begin
		if (quiet) m_tready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(5) == 0) begin
			stall_left <= $urandom_range(4);
			m_tready <= 1'b0;
		end else m_tready <= 1'b1;
	end

	// result checking and watchdog on transaction progress
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("watchdog: no transaction for %0d cycles", WDOG_MAX);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one command transaction; prediction is done at acceptance
	task send(logic [2:0] act, logic signed [16:0] pid, logic signed [8:0] prio);
		int gap;
		if (!quiet && $urandom_range(4) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, prio, pid, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(act, pid, prio);
		act_seen[act]++;
	endtask

	// wait for all answers, then let the block settle before a register write
	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_max_proc(logic [5:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'd0; pwdata <= {26'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.cap = v;
		@(posedge clk);
	endtask

	function automatic logic signed [16:0] rand_pid();
		int k;
		k = $urandom_range(99);
		if (k < 65) return 17'(sb.pick_live());
		if (k < 75) return -17'sd1;
		if (k < 90) return 17'($urandom_range(65535));
		return 17'(sb.pid_next);
	endfunction

	function automatic logic signed [8:0] rand_prio();
		int k;
		k = $urandom_range(99);
		if (k < 6) return -9'sd1;
		if (k < 9) return 9'(-$urandom_range(1, 256));
		if (k < 45) return 9'($urandom_range(3));   // many ties
		return 9'($urandom_range(255));
	endfunction

	task random_items(int count);
		logic [2:0] a;
		int k;
		repeat (count) begin
			k = $urandom_range(99);
			if (k < 22) a = ACT_CREATE;
			else if (k < 38) a = ACT_DISPATCH;
			else if (k < 44) a = ACT_REQUEUE;
			else if (k < 55) a = ACT_TERMINATE;
			else if (k < 67) a = ACT_SUSPEND;
			else if (k < 77) a = ACT_RESUME;
			else if (k < 87) a = ACT_CHANGE;
			else a = ACT_QUERY;
			send(a, rand_pid(), rand_prio());
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		quiet = 0; wdog = 0; stall_left = 0;
		s_tvalid = 0; s_tdata = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: empty-state corners, priority extremes, ties, scopes
		send(ACT_DISPATCH, 0, 0);         // ready list empty
		send(ACT_REQUEUE, 0, 0);          // nothing running
		send(ACT_SUSPEND, -1, 0);         // nothing running
		send(ACT_RESUME, -1, 0);          // empty resume-all is ok
		send(ACT_CREATE, 0, -1);          // bad priority
		send(ACT_CREATE, 0, 255);
		send(ACT_CREATE, 0, 0);
		send(ACT_CREATE, 0, 7);
		send(ACT_CREATE, 0, 7);           // tie keeps FIFO order
		send(ACT_DISPATCH, 0, 0);
		send(ACT_DISPATCH, 0, 0);         // running goes back by priority
		send(ACT_QUERY, 2, 0);
		send(ACT_CHANGE, 2, 0);           // ready entry moved to priority 0
		send(ACT_CHANGE, 3, -256);        // bad priority first
		send(ACT_SUSPEND, 3, 0);
		send(ACT_TERMINATE, 3, 0);        // suspended is out of scope
		send(ACT_CHANGE, 3, 1);           // suspended keeps place
		send(ACT_QUERY, 3, 0);
		send(ACT_SUSPEND, -1, 0);
		send(ACT_RESUME, 3, 0);
		send(ACT_RESUME, -1, 0);
		send(ACT_TERMINATE, 65535, 0);
		send(ACT_QUERY, -1, 0);
		send(ACT_REQUEUE, 0, 0);
		drain();

		// limit of one, then full store, a cap above the slot count, then small and default caps
		write_max_proc(6'd1);
		send(ACT_CREATE, 0, 5);
		send(ACT_CREATE, 0, 5);           // limit reached
		random_items(250);
		drain();
		write_max_proc(6'd32);
		repeat (34) send(ACT_CREATE, 0, rand_prio());
		random_items(450);
		drain();
		write_max_proc(6'd63);            // above the slot count
		random_items(300);
		drain();
		write_max_proc(6'd5);
		random_items(300);
		drain();
		write_max_proc(6'd20);
		random_items(150);
		quiet = 1;
		random_items(150);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d results; per action: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.checked, act_seen[0], act_seen[1], act_seen[2], act_seen[3],
			act_seen[4], act_seen[5], act_seen[6], act_seen[7]);
		$display("caps used: 1, 32, 63, 5, 20; %0d mismatches", sb.errors);
		if (sb.errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
